FILE: sv/zzr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zzr_pkg
// Shared types and constants for the zigzag row reorder block.
// ----------------------------------------------------------------------------
package zzr_pkg;

    // Field and register widths.
    localparam int CHAR_W   = 8;
    localparam int ROWS_W   = 7;
    localparam int PERIOD_W = 8;
    localparam int POS_W    = 9;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 1;

    // Register map and reset value.
    localparam logic [ADDR_W-1:0] REG_NUM_ROWS = 1'b0;
    localparam logic [ROWS_W-1:0] ROWS_RESET   = 7'd3;

    // Controller states.
    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } zzr_state_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic store;
        logic step;
    } zzr_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic msg_end;
        logic final_step;
        logic out_busy;
    } zzr_status_t;

endpackage

FILE: sv/zigzag_row_reorder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zigzag_row_reorder_top
// Rail-fence transposition of a byte message with an APB register port.
// ----------------------------------------------------------------------------
//  Channel | Handshake                 | Payload
//  --------+---------------------------+--------------------------------
//  input   | in_valid / in_stall       | char_in[7:0], is_last
//  output  | out_valid / out_stall     | char_out[7:0], last_out
//  config  | psel, penable, pwrite     | paddr[0:0], pwdata, prdata
//
//  Loading takes one byte per cycle into the message buffer.
//  Read-out gives one byte per cycle from the buffer's read port, plus an
//  idle step per row change and per missing second byte of an inner row.
//  Input stalls during read-out; an output stall holds the read-out.
//  No clearing pass after reset.
// ----------------------------------------------------------------------------
module zigzag_row_reorder_top #(
    parameter int MAX_LEN = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [zzr_pkg::CHAR_W-1:0]    char_in,
    input  logic                          is_last,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [zzr_pkg::CHAR_W-1:0]    char_out,
    output logic                          last_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [zzr_pkg::ADDR_W-1:0]    paddr,
    input  logic [zzr_pkg::DATA_W-1:0]    pwdata,
    output logic [zzr_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    zzr_pkg::zzr_cmd_t          cmd;
    zzr_pkg::zzr_status_t       status;
    logic                       cfg_we;
    logic [zzr_pkg::ROWS_W-1:0] num_rows;

    // Register port decode.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr == zzr_pkg::REG_NUM_ROWS);
    assign prdata = (paddr == zzr_pkg::REG_NUM_ROWS) ? zzr_pkg::DATA_W'(num_rows)
                                                     : '0;

    zzr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd),
        .in_stall  (in_stall)
    );

    zzr_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .out_stall (out_stall),
        .char_in   (char_in),
        .is_last   (is_last),
        .cfg_we    (cfg_we),
        .cfg_rows  (pwdata[zzr_pkg::ROWS_W-1:0]),
        .num_rows  (num_rows),
        .status    (status),
        .out_valid (out_valid),
        .char_out  (char_out),
        .last_out  (last_out)
    );

endmodule

FILE: sv/zzr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zzr_ctrl
// Controller: loads a message, then sequences the rail-order read-out.
// ----------------------------------------------------------------------------
module zzr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                out_stall,
    input  zzr_pkg::zzr_status_t status,
    output zzr_pkg::zzr_cmd_t    cmd,
    output logic                in_stall
);

    zzr_pkg::zzr_state_t state_reg;
    zzr_pkg::zzr_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= zzr_pkg::ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            zzr_pkg::ST_LOAD:
            begin
                if (in_valid && status.msg_end)
                begin
                    state_next = zzr_pkg::ST_EMIT;
                end
            end
            zzr_pkg::ST_EMIT:
            begin
                if ((!status.out_busy || !out_stall) && status.final_step)
                begin
                    state_next = zzr_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = zzr_pkg::ST_LOAD;
            end
        endcase
    end

    // Outputs: bytes are taken only while loading, and the read-out moves
    // whenever the output register is free or is being emptied.
    always_comb
    begin
        cmd.store = 1'b0;
        cmd.step  = 1'b0;
        in_stall  = 1'b1;
        case (state_reg)
            zzr_pkg::ST_LOAD:
            begin
                in_stall  = 1'b0;
                cmd.store = in_valid;
            end
            zzr_pkg::ST_EMIT:
            begin
                cmd.step = !status.out_busy || !out_stall;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

FILE: sv/zzr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zzr_datapath
// Message buffer, rail position counters and output register.
// ----------------------------------------------------------------------------
module zzr_datapath #(
    parameter int MAX_LEN = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  zzr_pkg::zzr_cmd_t             cmd,
    input  logic                          out_stall,
    input  logic [zzr_pkg::CHAR_W-1:0]    char_in,
    input  logic                          is_last,
    input  logic                          cfg_we,
    input  logic [zzr_pkg::ROWS_W-1:0]    cfg_rows,
    output logic [zzr_pkg::ROWS_W-1:0]    num_rows,
    output zzr_pkg::zzr_status_t          status,
    output logic                          out_valid,
    output logic [zzr_pkg::CHAR_W-1:0]    char_out,
    output logic                          last_out
);

    localparam int AW    = $clog2(MAX_LEN);
    localparam int LEN_W = $clog2(MAX_LEN + 1);
    localparam int POS_W = zzr_pkg::POS_W;

    logic [zzr_pkg::CHAR_W-1:0]   mem [MAX_LEN];

    logic [zzr_pkg::ROWS_W-1:0]   rows_reg;
    logic [LEN_W-1:0]             len_reg, len_next;
    logic [LEN_W-1:0]             cnt_reg, cnt_next;
    logic [zzr_pkg::ROWS_W-1:0]   row_reg, row_next;
    logic [POS_W-1:0]             base_reg, base_next;
    logic                         phase_reg, phase_next;
    logic [zzr_pkg::PERIOD_W-1:0] period_reg, period_next;
    logic                         thru_reg, thru_next;
    logic [zzr_pkg::ROWS_W-1:0]   rows_m1_reg, rows_m1_next;
    logic                         out_valid_reg, out_valid_next;
    logic                         last_out_reg;
    logic [zzr_pkg::CHAR_W-1:0]   char_out_reg;

    logic [LEN_W-1:0]             len_inc;
    logic [zzr_pkg::ROWS_W-1:0]   rows_eff;
    logic [POS_W-1:0]             len_ext;
    logic [POS_W-1:0]             pos;
    logic                         pos_ok;
    logic                         inner;
    logic                         final_hit;
    logic [AW-1:0]                rd_addr;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= zzr_pkg::ROWS_RESET;
        end
        else if (cfg_we)
        begin
            rows_reg <= cfg_rows;
        end
    end

    assign num_rows = rows_reg;

    // Message end: marked last, or the byte fills the final slot.
    assign len_inc        = len_reg + LEN_W'(1);
    assign status.msg_end = is_last || (len_inc == LEN_W'(MAX_LEN));

    // Read-out geometry, computed once the message length is known.
    assign rows_eff = (rows_reg == '0) ? zzr_pkg::ROWS_W'(1) : rows_reg;
    always_comb
    begin
        thru_next    = (rows_eff == zzr_pkg::ROWS_W'(1))
                    || (POS_W'(rows_eff) >= POS_W'(len_inc));
        period_next  = thru_next ? zzr_pkg::PERIOD_W'(1)
                                 : (zzr_pkg::PERIOD_W'(rows_eff) << 1)
                                   - zzr_pkg::PERIOD_W'(2);
        rows_m1_next = rows_eff - zzr_pkg::ROWS_W'(1);
    end

    // Current position: first or second byte of this period in this row.
    assign len_ext = POS_W'(len_reg);
    assign inner   = !thru_reg && (row_reg != '0) && (row_reg != rows_m1_reg);
    assign pos     = phase_reg
                   ? base_reg + POS_W'(period_reg) - POS_W'(row_reg)
                   : base_reg + POS_W'(row_reg);
    assign pos_ok  = pos < len_ext;
    assign rd_addr = pos[AW-1:0];

    assign final_hit         = pos_ok && ((cnt_reg + LEN_W'(1)) == len_reg);
    assign status.final_step = final_hit;
    assign status.out_busy   = out_valid_reg;

    // Counter and output control.
    always_comb
    begin
        len_next       = len_reg;
        cnt_next       = cnt_reg;
        row_next       = row_reg;
        base_next      = base_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg;

        if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.store)
        begin
            len_next = len_inc;
        end

        if (cmd.step)
        begin
            out_valid_next = pos_ok;
            if (pos_ok)
            begin
                cnt_next = cnt_reg + LEN_W'(1);
            end
            if (!phase_reg)
            begin
                if (!pos_ok)
                begin
                    // Row exhausted: go to the start of the next row.
                    row_next  = row_reg + zzr_pkg::ROWS_W'(1);
                    base_next = '0;
                end
                else if (inner)
                begin
                    phase_next = 1'b1;
                end
                else
                begin
                    base_next = base_reg + POS_W'(period_reg);
                end
            end
            else
            begin
                phase_next = 1'b0;
                base_next  = base_reg + POS_W'(period_reg);
            end
            if (final_hit)
            begin
                len_next   = '0;
                cnt_next   = '0;
                row_next   = '0;
                base_next  = '0;
                phase_next = 1'b0;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            cnt_reg       <= '0;
            row_reg       <= '0;
            base_reg      <= '0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            cnt_reg       <= cnt_next;
            row_reg       <= row_next;
            base_reg      <= base_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Geometry registers, loaded when the message ends.
    always_ff @(posedge clk)
    begin
        if (cmd.store && status.msg_end)
        begin
            thru_reg    <= thru_next;
            period_reg  <= period_next;
            rows_m1_reg <= rows_m1_next;
        end
    end

    // Message buffer: write while loading.
    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            mem[len_reg[AW-1:0]] <= char_in;
        end
    end

    // Registered read straight into the output register.
    always_ff @(posedge clk)
    begin
        if (cmd.step && pos_ok)
        begin
            char_out_reg <= mem[rd_addr];
            last_out_reg <= final_hit;
        end
    end

    assign out_valid = out_valid_reg;
    assign char_out  = char_out_reg;
    assign last_out  = last_out_reg;

endmodule

FILE: sv/zzr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zzr_checker
// Port-level checks of the zigzag row reorder block.
// ----------------------------------------------------------------------------
module zzr_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_stall,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic [zzr_pkg::CHAR_W-1:0] char_out,
    input logic                       last_out
);

    // A stalled output transaction holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(char_out) && $stable(last_out))
    else $error("output transaction changed while stalled");

    // Input stall only begins after an input transaction ends a message.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(in_valid))
    else $error("input stalled without a message end");

    // Input reopens exactly when the final reordered byte is presented.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_stall) |-> out_valid && last_out)
    else $error("input reopened before the final byte was presented");

endmodule

bind zigzag_row_reorder_top zzr_checker u_zzr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .char_out  (char_out),
    .last_out  (last_out)
);

FILE: tb/zigzag_row_reorder_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zigzag_row_reorder_top_tb
// Self-checking testbench for the rail-fence byte reorder block.
// Messages are pushed through the input channel while the output channel is
// compared against a behavioral rail-fence predictor. The rail count is
// reprogrammed over APB between phases, and both channels idle at random.
// ----------------------------------------------------------------------------
module zigzag_row_reorder_top_tb;

    localparam int MSG_MAX     = 64;
    localparam int NUM_PLANNED = 7;
    localparam int NUM_PHASES  = 9;
    localparam int PHASE_ITEMS = 16;
    localparam int DIR_ROWS    = 19;
    localparam int DRAIN_CYC   = 8;
    localparam int MAX_REPORTS = 10;

    // Address with no register behind it; writes there must be ignored.
    localparam logic [zzr_pkg::ADDR_W-1:0] ADDR_UNMAPPED = 1'b1;

    // One byte of the reordered message.
    typedef struct packed {
        logic [zzr_pkg::CHAR_W-1:0] ch;
        logic                       lst;
    } rail_byte_t;

    // One row of directed stimulus. When known is set the row ends a
    // one-byte message whose single output byte is typed in directly.
    typedef struct packed {
        logic [zzr_pkg::CHAR_W-1:0] ch;
        logic                       lst;
        logic                       known;
        logic [zzr_pkg::CHAR_W-1:0] known_ch;
    } dir_row_t;

    logic                       clk;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    logic                       in_stall;
    logic [zzr_pkg::CHAR_W-1:0] char_in   = '0;
    logic                       is_last   = 1'b0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [zzr_pkg::CHAR_W-1:0] char_out;
    logic                       last_out;
    logic                       psel      = 1'b0;
    logic                       penable   = 1'b0;
    logic                       pwrite    = 1'b0;
    logic [zzr_pkg::ADDR_W-1:0] paddr     = '0;
    logic [zzr_pkg::DATA_W-1:0] pwdata    = '0;
    logic [zzr_pkg::DATA_W-1:0] prdata;
    logic                       pready;

    // Predictor state.
    logic [zzr_pkg::CHAR_W-1:0] msg_buf [MSG_MAX];
    int                         msg_len   = 0;
    int                         emitted   = 0;
    logic [zzr_pkg::ROWS_W-1:0] rows_cfg  = zzr_pkg::ROWS_RESET;
    rail_byte_t                 reorder_q [$];

    int error_count   = 0;
    int send_idle_pct = 19;
    int stall_pct     = 82;

    // Rail counts for the planned phases; later phases pick one at random.
    int rows_plan [NUM_PLANNED] = '{0, 1, 2, 4, 63, 64, 127};

    dir_row_t directed_rows [DIR_ROWS] = '{
        // One-byte messages at the byte extremes.
        '{8'h00, 1'b1, 1'b1, 8'h00},
        '{8'hFF, 1'b1, 1'b1, 8'hFF},
        // Two bytes with three rails: more rails than bytes.
        '{8'h5A, 1'b0, 1'b0, 8'h00},
        '{8'hA5, 1'b1, 1'b0, 8'h00},
        // Seven bytes: inner row with a missing second byte at the tail.
        '{8'h41, 1'b0, 1'b0, 8'h00},
        '{8'h42, 1'b0, 1'b0, 8'h00},
        '{8'h43, 1'b0, 1'b0, 8'h00},
        '{8'h44, 1'b0, 1'b0, 8'h00},
        '{8'h45, 1'b0, 1'b0, 8'h00},
        '{8'h46, 1'b0, 1'b0, 8'h00},
        '{8'h47, 1'b1, 1'b0, 8'h00},
        // Eight bytes: single-bit patterns and two of their complements.
        '{8'h80, 1'b0, 1'b0, 8'h00},
        '{8'h01, 1'b0, 1'b0, 8'h00},
        '{8'h7F, 1'b0, 1'b0, 8'h00},
        '{8'hFE, 1'b0, 1'b0, 8'h00},
        '{8'h10, 1'b0, 1'b0, 8'h00},
        '{8'h20, 1'b0, 1'b0, 8'h00},
        '{8'h40, 1'b0, 1'b0, 8'h00},
        '{8'h08, 1'b1, 1'b0, 8'h00}
    };

    zigzag_row_reorder_top #(
        .MAX_LEN (MSG_MAX)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .char_in   (char_in),
        .is_last   (is_last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .char_out  (char_out),
        .last_out  (last_out),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // Free-running clock, 12 ns period.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Run limit in case the block hangs.
    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Counts a failure and reports the first few of them.
    function automatic void note_mismatch(string what, int exp_v, int act_v);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("MISMATCH %s: expected %0h, got %0h at %0t ns",
                     what, exp_v, act_v, $time);
    endfunction

    // Appends the byte at a message position to the expected results.
    function automatic void push_rail_byte(int pos);
        rail_byte_t b;
        b.ch  = msg_buf[pos];
        b.lst = (emitted + 1 == msg_len);
        reorder_q.push_back(b);
        emitted++;
    endfunction

    // Stores one accepted byte and, when the message ends, predicts the
    // whole read-out in rail-fence order.
    function automatic void predict_reorder(logic [zzr_pkg::CHAR_W-1:0] ch, logic lst);
        int rails;
        int period;
        bit inner;
        msg_buf[msg_len] = ch;
        msg_len++;
        if (!lst && msg_len < MSG_MAX)
            return;
        rails   = (rows_cfg == 0) ? 1 : int'(rows_cfg);
        emitted = 0;
        if (rails == 1 || rails >= msg_len)
        begin
            for (int i = 0; i < msg_len; i++)
                push_rail_byte(i);
        end
        else
        begin
            period = 2 * rails - 2;
            for (int r = 0; r < rails; r++)
            begin
                inner = (r != 0) && (r != rails - 1);
                for (int b = 0; b + r < msg_len; b += period)
                begin
                    push_rail_byte(b + r);
                    if (inner && (b + period - r < msg_len))
                        push_rail_byte(b + period - r);
                end
            end
        end
        msg_len = 0;
    endfunction

    // Receiver stall, redrawn every cycle.
    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < stall_pct);

    // Compare every output transaction with the oldest expected byte.
    always @(posedge clk)
    begin
        rail_byte_t exp_b;
        if (rst_n && out_valid && !out_stall)
        begin
            if (reorder_q.size() == 0)
                note_mismatch("unexpected char_out,last_out", 0,
                              int'({char_out, last_out}));
            else
            begin
                exp_b = reorder_q.pop_front();
                if (char_out !== exp_b.ch || last_out !== exp_b.lst)
                    note_mismatch("char_out,last_out", int'(exp_b),
                                  int'({char_out, last_out}));
            end
        end
    end

    // APB write followed by a readback of the rail count.
    task automatic cfg_write(input logic [zzr_pkg::ADDR_W-1:0] addr,
                             input logic [zzr_pkg::DATA_W-1:0] wdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (addr == zzr_pkg::REG_NUM_ROWS)
            rows_cfg = wdata[zzr_pkg::ROWS_W-1:0];
        pwrite  <= 1'b0;
        penable <= 1'b0;
        paddr   <= zzr_pkg::REG_NUM_ROWS;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[zzr_pkg::ROWS_W-1:0] !== rows_cfg)
            note_mismatch("num_rows readback", int'(rows_cfg),
                          int'(prdata[zzr_pkg::ROWS_W-1:0]));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Offers one byte, waits for the transaction and updates the predictor.
    // Valid is left high so a following byte can go out back to back.
    task automatic send_item(input logic [zzr_pkg::CHAR_W-1:0] ch, input logic lst);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        char_in  <= ch;
        is_last  <= lst;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_reorder(ch, lst);
    endtask

    // Stops sending and waits until the block has gone idle.
    task automatic finish_phase();
        in_valid <= 1'b0;
        while (reorder_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    // Main stimulus sequence.
    initial
    begin
        logic [zzr_pkg::DATA_W-1:0] wdata;
        int rows;
        int sent;
        int len;
        int r;
        bit big;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A write to an unmapped address must leave the reset rail count.
        cfg_write(ADDR_UNMAPPED, $urandom());

        // Directed messages at the reset rail count.
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            send_item(directed_rows[i].ch, directed_rows[i].lst);
            if (directed_rows[i].known)
            begin
                void'(reorder_q.pop_back());
                reorder_q.push_back(rail_byte_t'{directed_rows[i].known_ch, 1'b1});
            end
        end
        finish_phase();

        // Random messages over a series of rail counts and idle patterns.
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            if (phase < 3)
            begin
                send_idle_pct = 19;
                stall_pct     = 82;
            end
            else if (phase < 6)
            begin
                send_idle_pct = 82;
                stall_pct     = 19;
            end
            else
            begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end

            rows = (phase < NUM_PLANNED) ? rows_plan[phase] : $urandom_range(2, 20);
            wdata = $urandom();
            wdata[zzr_pkg::ROWS_W-1:0] = rows[zzr_pkg::ROWS_W-1:0];
            cfg_write(zzr_pkg::REG_NUM_ROWS, wdata);

            // Large rail counts get a long message first so they matter.
            // Other messages are trimmed to the items left in the phase.
            big  = (rows >= 32);
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                r = $urandom_range(0, 9);
                if (big && sent == 0)
                    len = $urandom_range(62, 70);
                else if (r < 6)
                    len = $urandom_range(1, 16);
                else if (r < 8)
                    len = $urandom_range(17, 40);
                else
                    len = $urandom_range(60, 70);
                if (!(big && sent == 0) && len > PHASE_ITEMS - sent)
                    len = PHASE_ITEMS - sent;
                for (int i = 0; i < len; i++)
                    send_item(zzr_pkg::CHAR_W'($urandom_range(0, 255)), i == len - 1);
                sent += len;
            end
            finish_phase();
        end

        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
